// File: rtl/apsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apsc_pkg
// Types, constants and helper functions shared by the archive path safety
// checker: verdict codes, per-name scan state and component rules.
// ----------------------------------------------------------------------------
package apsc_pkg;

	// Verdict codes, in the encoding seen on the result port
	typedef enum logic [3:0] {
		V_SAFE         = 4'd0,
		V_EMPTY        = 4'd1,
		V_NUL          = 4'd2,
		V_CONTROL      = 4'd3,
		V_TOO_LONG     = 4'd4,
		V_ABS_POSIX    = 4'd5,
		V_DRIVE        = 4'd6,
		V_UNC          = 4'd7,
		V_BACKSLASH    = 4'd8,
		V_PARENT       = 4'd9,
		V_CURRENT      = 4'd10,
		V_EMPTY_COMP   = 4'd11,
		V_RESERVED     = 4'd12,
		V_TRAILING     = 4'd13,
		V_INVALID_ROOT = 4'd14
	} verdict_t;

	// First bad component seen in the name
	typedef enum logic [2:0] {
		BAD_NONE     = 3'd0,
		BAD_EMPTY    = 3'd1,
		BAD_PARENT   = 3'd2,
		BAD_CURRENT  = 3'd3,
		BAD_TRAILING = 3'd4,
		BAD_RESERVED = 3'd5
	} bad_t;

	// Configuration register indexes
	typedef enum logic [1:0] {
		CFG_ROOT_VALID   = 2'd0,
		CFG_MAX_NAME_LEN = 2'd1,
		CFG_MAX_DEPTH    = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic nul;
		logic ctrl;
		logic bsl;
		logic unc;
		logic drive;
	} flags_t;

	// Record of the component being scanned
	typedef struct packed {
		logic [1:0]      len;
		logic            all_dots;
		logic [3:0][7:0] stem;
		logic [2:0]      stem_len;
		logic            stem_done;
	} comp_t;

	// Per-name scan state
	typedef struct packed {
		logic [10:0] name_len;
		logic [7:0]  first_c;
		logic [7:0]  prev_c;
		flags_t      flags;
		comp_t       comp;
		logic [6:0]  comp_cnt;
		bad_t        bad;
	} scan_t;

	localparam logic [10:0] NAME_LEN_SAT = 11'd2047;
	localparam logic [6:0]  COMP_CNT_SAT = 7'd127;
	localparam logic [1:0]  COMP_LEN_SAT = 2'd3;
	localparam logic [2:0]  STEM_LEN_SAT = 3'd5;
	localparam logic [2:0]  STEM_KEEP    = 3'd4;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_DEL    = 8'h7F;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_COLON  = 8'h3A;

	localparam logic [23:0] STEM_CON = "CON";
	localparam logic [23:0] STEM_PRN = "PRN";
	localparam logic [23:0] STEM_AUX = "AUX";
	localparam logic [23:0] STEM_NUL = "NUL";
	localparam logic [23:0] STEM_COM = "COM";
	localparam logic [23:0] STEM_LPT = "LPT";

	localparam logic       ROOT_VALID_RST   = 1'b1;
	localparam logic [9:0] MAX_NAME_LEN_RST = 10'd512;
	localparam logic [5:0] MAX_DEPTH_RST    = 6'd32;

	localparam comp_t COMP_RESET = '{
		len: 2'd0, all_dots: 1'b1, stem: '0, stem_len: 3'd0, stem_done: 1'b0
	};

	localparam scan_t SCAN_RESET = '{
		name_len: 11'd0, first_c: 8'd0, prev_c: 8'd0, flags: '0,
		comp: COMP_RESET, comp_cnt: 7'd0, bad: BAD_NONE
	};

	// Latin-1 letter for the drive check
	function automatic logic is_letter(input logic [7:0] c);
		logic res;
		res = (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") ||
			(c == 8'hAA) || (c == 8'hB5) || (c == 8'hBA) ||
			(c >= 8'hC0 && c != 8'hD7 && c != 8'hF7);
		return res;
	endfunction

	// ASCII upper-case only
	function automatic logic [7:0] to_upper(input logic [7:0] c);
		logic [7:0] res;
		res = (c >= "a" && c <= "z") ? c - 8'd32 : c;
		return res;
	endfunction

	// Reserved device stem, case-folded
	function automatic logic stem_reserved(input comp_t cp);
		logic [23:0] s3;
		logic        res;
		s3  = {cp.stem[0], cp.stem[1], cp.stem[2]};
		res = 1'b0;
		if (cp.stem_len == 3'd3)
			res = (s3 == STEM_CON) || (s3 == STEM_PRN) ||
				(s3 == STEM_AUX) || (s3 == STEM_NUL);
		else if (cp.stem_len == 3'd4 && (s3 == STEM_COM || s3 == STEM_LPT))
			res = (cp.stem[3] >= "1") && (cp.stem[3] <= "9");
		return res;
	endfunction

	// Close a component: keep the first bad one
	function automatic bad_t finish_bad(input bad_t bad, input comp_t cp,
		input logic [7:0] last_c);
		bad_t res;
		res = bad;
		if (bad == BAD_NONE) begin
			if (cp.len == 2'd0)
				res = BAD_EMPTY;
			else if (cp.all_dots && cp.len == 2'd2)
				res = BAD_PARENT;
			else if (cp.all_dots && cp.len == 2'd1)
				res = BAD_CURRENT;
			else if (last_c == CH_DOT || last_c == CH_SPACE)
				res = BAD_TRAILING;
			else if (stem_reserved(cp))
				res = BAD_RESERVED;
		end
		return res;
	endfunction

endpackage

// File: rtl/apsc_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apsc_scan
// Per-name scan state: flags, counters and the current component record,
// updated once per character, cleared after each verdict.
// ----------------------------------------------------------------------------
module apsc_scan (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               take,
	input  logic               clear,
	input  logic [7:0]         character,
	output apsc_pkg::scan_t    post
);
	import apsc_pkg::*;

	scan_t state_q;
	scan_t nxt;

	// Fold one character into the scan state
	always_comb begin
		nxt = state_q;
		if (state_q.name_len == 11'd0)
			nxt.first_c = character;
		if (state_q.name_len == 11'd1) begin
			if (character == state_q.first_c &&
				(character == CH_SLASH || character == CH_BSLASH))
				nxt.flags.unc = 1'b1;
			if (character == CH_COLON && is_letter(state_q.first_c))
				nxt.flags.drive = 1'b1;
		end
		if (state_q.name_len != NAME_LEN_SAT)
			nxt.name_len = state_q.name_len + 11'd1;
		if (character == CH_NUL)
			nxt.flags.nul = 1'b1;
		if (character < CH_SPACE || character == CH_DEL)
			nxt.flags.ctrl = 1'b1;
		if (character == CH_BSLASH)
			nxt.flags.bsl = 1'b1;

		if (character == CH_SLASH) begin
			// close the component before the slash
			nxt.bad = finish_bad(state_q.bad, state_q.comp, state_q.prev_c);
			if (state_q.comp_cnt != COMP_CNT_SAT)
				nxt.comp_cnt = state_q.comp_cnt + 7'd1;
			nxt.comp = COMP_RESET;
		end else begin
			if (state_q.comp.len != COMP_LEN_SAT)
				nxt.comp.len = state_q.comp.len + 2'd1;
			if (character != CH_DOT)
				nxt.comp.all_dots = 1'b0;
			// collect the stem up to the first dot
			if (!state_q.comp.stem_done) begin
				if (character == CH_DOT) begin
					nxt.comp.stem_done = 1'b1;
				end else if (state_q.comp.stem_len < STEM_LEN_SAT) begin
					if (state_q.comp.stem_len < STEM_KEEP)
						nxt.comp.stem[state_q.comp.stem_len[1:0]] = to_upper(character);
					nxt.comp.stem_len = state_q.comp.stem_len + 3'd1;
				end
			end
		end
		nxt.prev_c = character;
	end

	assign post = take ? nxt : state_q;

	// Hold state; clear after a verdict
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SCAN_RESET;
		end else if (clear) begin
			state_q <= SCAN_RESET;
		end else if (take) begin
			state_q <= nxt;
		end
	end

endmodule

// File: rtl/apsc_judge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apsc_judge
// Verdict selection: applies the checks in priority order to the scan state
// that includes the final character, closing the last component if open.
// ----------------------------------------------------------------------------
module apsc_judge (
	input  apsc_pkg::scan_t    post,
	input  logic               root_valid,
	input  logic [9:0]         max_name_length,
	input  logic [5:0]         max_depth,
	output apsc_pkg::verdict_t verdict
);
	import apsc_pkg::*;

	logic [6:0] cnt_end;
	bad_t       bad_end;
	verdict_t   comp_code;

	// Close the last component unless the name ends in a slash
	always_comb begin
		cnt_end = post.comp_cnt;
		bad_end = post.bad;
		if (post.prev_c != CH_SLASH) begin
			bad_end = finish_bad(post.bad, post.comp, post.prev_c);
			if (post.comp_cnt != COMP_CNT_SAT)
				cnt_end = post.comp_cnt + 7'd1;
		end
	end

	// Map bad component to its verdict
	always_comb begin
		case (bad_end)
			BAD_EMPTY:    comp_code = V_EMPTY_COMP;
			BAD_PARENT:   comp_code = V_PARENT;
			BAD_CURRENT:  comp_code = V_CURRENT;
			BAD_TRAILING: comp_code = V_TRAILING;
			BAD_RESERVED: comp_code = V_RESERVED;
			default:      comp_code = V_SAFE;
		endcase
	end

	// Priority chain
	always_comb begin
		if (!root_valid)
			verdict = V_INVALID_ROOT;
		else if (post.name_len == 11'd0)
			verdict = V_EMPTY;
		else if (post.flags.nul)
			verdict = V_NUL;
		else if (post.flags.ctrl)
			verdict = V_CONTROL;
		else if (post.name_len > {1'b0, max_name_length})
			verdict = V_TOO_LONG;
		else if (post.flags.unc)
			verdict = V_UNC;
		else if (post.flags.drive)
			verdict = V_DRIVE;
		else if (post.first_c == CH_SLASH)
			verdict = V_ABS_POSIX;
		else if (post.first_c == CH_BSLASH || post.flags.bsl)
			verdict = V_BACKSLASH;
		else if (cnt_end > {1'b0, max_depth})
			verdict = V_TOO_LONG;
		else
			verdict = comp_code;
	end

endmodule

// File: rtl/archive_path_safety_checker_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// archive_path_safety_checker_core
// Checks an archive entry name, fed one Latin-1 character per item, and
// returns one verdict code after the item marked last.
// ----------------------------------------------------------------------------
// The block takes one character item every cycle while char_stall is low. Each
// item is captured in an input register and then folded into the per-name scan
// state; for the item marked last the verdict is chosen as that item is folded
// in and held in the result register, which drives verdict_valid. Items that
// are not last pass even while a verdict waits; a last item holds in the input
// register only while the previous verdict is still stalled. Configuration
// writes are always ready and should be made while no name is in flight.
module archive_path_safety_checker_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       char_valid,
	output logic       char_stall,
	input  logic [7:0] character,
	input  logic       present,
	input  logic       last,
	output logic       verdict_valid,
	input  logic       verdict_stall,
	output logic [3:0] verdict,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [9:0] cfg_data
);
	import apsc_pkg::*;

	logic       root_valid_q;
	logic [9:0] max_name_len_q;
	logic [5:0] max_depth_q;

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       present_s1;
	logic       last_s1;
	logic       adv_s1;

	logic       verdict_valid_q;
	logic [3:0] verdict_q;

	scan_t      post;
	verdict_t   verdict_nx;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_valid_q   <= ROOT_VALID_RST;
			max_name_len_q <= MAX_NAME_LEN_RST;
			max_depth_q    <= MAX_DEPTH_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_ROOT_VALID:   root_valid_q   <= cfg_data[0];
				CFG_MAX_NAME_LEN: max_name_len_q <= cfg_data;
				CFG_MAX_DEPTH:    max_depth_q    <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	// Advance unless a last item would overwrite a stalled verdict
	assign adv_s1     = valid_s1 && !(last_s1 && verdict_valid_q && verdict_stall);
	assign char_stall = valid_s1 && !adv_s1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (char_valid && !char_stall) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (char_valid && !char_stall) begin
			char_s1    <= character;
			present_s1 <= present;
			last_s1    <= last;
		end
	end

	apsc_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (adv_s1 && present_s1),
		.clear     (adv_s1 && last_s1),
		.character (char_s1),
		.post      (post)
	);

	apsc_judge u_judge (
		.post            (post),
		.root_valid      (root_valid_q),
		.max_name_length (max_name_len_q),
		.max_depth       (max_depth_q),
		.verdict         (verdict_nx)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			verdict_valid_q <= 1'b0;
		end else if (adv_s1 && last_s1) begin
			verdict_valid_q <= 1'b1;
		end else if (!verdict_stall) begin
			verdict_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && last_s1) begin
			verdict_q <= verdict_nx;
		end
	end

	assign verdict_valid = verdict_valid_q;
	assign verdict       = verdict_q;

endmodule

// File: rtl/apsc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apsc_checker
// Port-level checks for the archive path safety checker, bound to the core.
// ----------------------------------------------------------------------------
module apsc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       char_valid,
	input logic       char_stall,
	input logic       last,
	input logic       verdict_valid,
	input logic       verdict_stall,
	input logic [3:0] verdict,
	input logic       cfg_valid,
	input logic       cfg_ready
);
	import apsc_pkg::*;

	// Hold a stalled verdict
	a_verdict_hold: assert property (@(posedge clk) disable iff (!arst_n)
		verdict_valid && verdict_stall |=> verdict_valid && $stable(verdict))
		else $error("stalled verdict changed or dropped");

	// A fresh verdict follows an accepted last item
	a_verdict_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(verdict_valid) |-> $past(char_valid && !char_stall && last, 2))
		else $error("verdict without a last item");

	// Only defined codes leave the block
	a_verdict_code: assert property (@(posedge clk) disable iff (!arst_n)
		verdict_valid |-> verdict <= V_INVALID_ROOT)
		else $error("undefined verdict code");

	// Configuration writes never wait
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write held off");

endmodule

bind archive_path_safety_checker_core apsc_checker u_apsc_checker (.*);
